// File: rtl/lnp_pkg.sv
// ----------------------------------------------------------------------------
// lnp_pkg
// Constants and helper functions for the line number prefixer.
// ----------------------------------------------------------------------------
package lnp_pkg;

    localparam int PAD_COLUMNS  = 6;
    localparam int COUNT_DIGITS = 10;

    localparam int BCD_W      = 4 * COUNT_DIGITS;
    localparam int DIG_IDX_W  = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;
    // longest prefix: widest of pad field and full count, plus the tab
    localparam int PREFIX_MAX = ((PAD_COLUMNS > COUNT_DIGITS) ? PAD_COLUMNS : COUNT_DIGITS) + 1;
    localparam int POS_W      = $clog2(PREFIX_MAX + 1);

    localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef logic [BCD_W-1:0] bcd_t;
    typedef logic [POS_W-1:0] pos_t;

    // Add one to a BCD count; all nines wraps to zero.
    function automatic bcd_t bcd_increment(input bcd_t v);
        bcd_t       r;
        logic       carry;
        logic [3:0] d;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            d = v[i*4 +: 4];
            if (carry) begin
                r[i*4 +: 4] = (d >= 4'd9) ? 4'd0 : d + 4'd1;
            end
            carry = carry & (d >= 4'd9);
        end
        return r;
    endfunction

    // Number of significant digits, at least one.
    function automatic pos_t digit_len(input bcd_t v);
        pos_t len;
        len = pos_t'(1);
        for (int i = 1; i < COUNT_DIGITS; i++) begin
            if (v[i*4 +: 4] != 4'd0) begin
                len = pos_t'(i + 1);
            end
        end
        return len;
    endfunction

    function automatic logic bcd_valid(input bcd_t v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            ok = ok & (v[i*4 +: 4] <= 4'd9);
        end
        return ok;
    endfunction

endpackage

// File: rtl/line_number_prefixer.sv
// ----------------------------------------------------------------------------
// line_number_prefixer
// Inserts a right-justified decimal line number and a tab before each line.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: one text byte per transfer in tdata; tuser set on
//   the first byte of a file restarts the line count at 1 and starts a line.
//   Output stream m_axis: one byte per transfer; tlast marks the copied text
//   byte, which ends the output run of each input transfer.
//   A byte inside a line is copied on; the block takes one input transfer per
//   cycle there while m_axis_tready holds. A byte at a line start first emits
//   the prefix (pad spaces, the digits, a tab), one byte per cycle from a single
//   output register while m_axis_tready holds, and holds the input till then.
//   An input goes through the holding register, then the output register.
//   The count is ten BCD digits, wraps to zero, and numbers wider than six
//   columns are printed in full without padding.
//   Reset sets the count to 1, marks the start of a line and empties both
//   the holding register and the output register.
//   When the receiver stalls, the output register holds its byte and the
//   holding register stops, so s_axis_tready drops once it is full.
// ----------------------------------------------------------------------------
module line_number_prefixer (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tuser,   // [0] first_of_file

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast    // last_of_run
);
    import lnp_pkg::*;

    // holding register for the item in progress
    logic        hold_valid_reg, hold_valid_next;
    logic [7:0]  hold_byte_reg;
    logic        hold_first_reg;
    pos_t        pos_reg, pos_next;

    // line state
    bcd_t        count_reg, count_next;
    logic        line_start_reg, line_start_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_last_reg, out_last_next;

    bcd_t                 eff_count;
    logic                 eff_start;
    pos_t                 len, pad_n, plen, off, idx_wide;
    logic [DIG_IDX_W-1:0] idx;
    logic                 out_free, emit, is_text, finish, s_accept;
    logic [7:0]           prefix_byte;

    assign eff_count = hold_first_reg ? BCD_ONE : count_reg;
    assign eff_start = hold_first_reg | line_start_reg;

    assign len      = digit_len(eff_count);
    assign pad_n    = (len < pos_t'(PAD_COLUMNS)) ? pos_t'(PAD_COLUMNS) - len : '0;
    assign plen     = pad_n + len + pos_t'(1);
    assign off      = pos_reg - pad_n;
    assign idx_wide = len - pos_t'(1) - off;
    assign idx      = idx_wide[DIG_IDX_W-1:0];

    always_comb begin
        priority if (pos_reg < pad_n) begin
            prefix_byte = CH_SPACE;
        end else if (pos_reg < pad_n + len) begin
            prefix_byte = CH_ZERO + {4'd0, eff_count[idx*4 +: 4]};
        end else begin
            prefix_byte = CH_TAB;
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign emit          = hold_valid_reg && out_free;
    assign is_text       = !eff_start || (pos_reg == plen);
    assign finish        = emit && is_text;
    assign s_axis_tready = !hold_valid_reg || finish;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        line_start_next = line_start_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        if (emit) begin
            out_valid_next = 1'b1;
            out_byte_next  = is_text ? hold_byte_reg : prefix_byte;
            out_last_next  = is_text;
            pos_next       = pos_reg + pos_t'(1);
        end
        if (finish) begin
            hold_valid_next = 1'b0;
            pos_next        = '0;
            count_next      = eff_start ? bcd_increment(eff_count) : count_reg;
            line_start_next = (hold_byte_reg == CH_NL);
        end
        if (s_accept) begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            pos_reg        <= '0;
            count_reg      <= BCD_ONE;
            line_start_reg <= 1'b1;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            line_start_reg <= line_start_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_byte_reg  <= s_axis_tdata;
            hold_first_reg <= s_axis_tuser;
        end
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // count digits stay decimal
    assert property (@(posedge aclk) disable iff (!aresetn) bcd_valid(count_reg))
        else $error("line count holds a non-decimal digit");

    // prefix position never runs past the text byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (!eff_start || pos_reg <= plen))
        else $error("prefix position out of range");

    // a copied newline starts the next line
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && hold_byte_reg == CH_NL) |=> line_start_reg)
        else $error("newline did not mark a line start");

    // a prefix byte never carries tlast
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !is_text) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("prefix byte flagged as last");

endmodule
